[hw/rtl/gaws_pkg.sv]
package gaws_pkg;

  localparam int GridTiles   = 16;
  localparam int MaxTileSide = 64;
  localparam int AlphaW      = 8;
  localparam int WidthW      = 11;
  localparam int PixXW       = 10;
  localparam int PixYW       = 11;
  localparam int SideW       = 7;
  localparam int LocW        = 6;
  localparam int TileW       = 4;
  localparam int GlyphW      = 8;
  localparam int FracW       = 16;
  localparam int NumW        = LocW + FracW;
  localparam int RecipShift  = 28;
  localparam int RecipW      = RecipShift + 1;
  localparam int ProdW       = NumW + RecipW;
  localparam int QuotW       = ProdW - RecipShift;
  localparam int DivSteps    = PixYW;
  localparam int DivCntW     = 4;

  localparam logic [WidthW-1:0] WidthMin   = WidthW'(GridTiles);
  localparam logic [WidthW-1:0] WidthMax   = WidthW'(GridTiles * MaxTileSide);
  localparam logic [WidthW-1:0] WidthReset = WidthW'(256);
  localparam logic [PixYW-1:0]  PixelYMax  = PixYW'(GridTiles * MaxTileSide);
  localparam logic [GlyphW-1:0] SpaceGlyph = GlyphW'(32);
  localparam logic [FracW-1:0]  HalfQ16    = 16'h8000;
  localparam logic [FracW-1:0]  FracMax    = 16'hffff;

  typedef struct packed {
    logic [AlphaW-1:0] alpha;
    logic              frame_start;
  } pixel_t;

  typedef struct packed {
    logic [GlyphW-1:0] glyph_index;
    logic [LocW-1:0]   rightmost_column;
    logic [FracW-1:0]  width_fraction;
  } result_t;

  typedef struct packed {
    logic             start;
    logic             in_span;
    logic             first;
    logic             inner;
    logic             last;
    logic [LocW-1:0]  lx;
    logic [TileW-1:0] tx;
    logic [TileW-1:0] ty;
  } pos_t;

  typedef struct packed {
    logic              valid;
    logic [GlyphW-1:0] glyph;
    logic [LocW-1:0]   col;
  } done_t;

endpackage

[hw/rtl/glyph_atlas_width_scan.sv]
// a result for a tile is registered through the s1, done, p and result stages after the pixel that completes its tile
// throughput: one pixel per cycle while the result side keeps taking results and no position recompute is running
// a width write is followed by a position recompute in the two
// restoring dividers, during which pixels are stalled and width_ready is low
// reset: width 256, position at the origin, all tile column maxima zero
module glyph_atlas_width_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  gaws_pkg::pixel_t            pixel,
  output logic                        result_valid,
  input  logic                        result_stall,
  output gaws_pkg::result_t           result,
  input  logic                        width_valid,
  output logic                        width_ready,
  input  logic [gaws_pkg::WidthW-1:0] width_data
);
  import gaws_pkg::*;

  logic [WidthW-1:0] image_width;
  logic [WidthW-1:0] width_eff;
  logic [SideW-1:0]  side;
  logic              advance;
  logic              accept;
  logic              busy;
  logic              cfg_write;
  pos_t              pos;
  done_t             done;

  always_comb begin
    if (image_width < WidthMin) begin
      width_eff = WidthMin;
    end else if (image_width > WidthMax) begin
      width_eff = WidthMax;
    end else begin
      width_eff = image_width;
    end
  end

  assign side = width_eff[WidthW-1:4];

  assign advance     = !result_valid || !result_stall;
  assign pixel_stall = !advance || busy;
  assign accept      = pixel_valid && !pixel_stall;
  assign width_ready = !busy;
  assign cfg_write   = width_valid && width_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
    end else if (cfg_write) begin
      image_width <= width_data;
    end
  end

  gaws_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (pixel.frame_start),
    .cfg_write   (cfg_write),
    .width_eff   (width_eff),
    .side        (side),
    .pos         (pos),
    .busy        (busy)
  );

  gaws_colmem u_colmem (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .accept  (accept),
    .alpha   (pixel.alpha),
    .pos     (pos),
    .done    (done)
  );

  gaws_frac u_frac (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .done         (done),
    .side         (side),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

[hw/rtl/gaws_div.sv]
module gaws_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gaws_pkg::PixYW-1:0] dividend,
  input  logic [gaws_pkg::SideW-1:0] divisor,
  output logic                      busy,
  output logic [gaws_pkg::TileW-1:0] quotient_lo,
  output logic [gaws_pkg::LocW-1:0]  remainder
);
  import gaws_pkg::*;

  logic [DivCntW-1:0] count;
  logic [PixYW-1:0]   shreg;
  logic [LocW-1:0]    acc;
  logic [SideW-1:0]   trial;
  logic               take;

  assign trial = {acc, shreg[PixYW-1]};
  assign take  = trial >= divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
      acc   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      acc   <= take ? LocW'(trial - divisor) : trial[LocW-1:0];
      shreg <= {shreg[PixYW-2:0], take};
      count <= DivCntW'(count + 1'b1);
      if (count == DivCntW'(DivSteps - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient_lo = shreg[TileW-1:0];
  assign remainder   = acc;

endmodule

[hw/rtl/gaws_pos.sv]
module gaws_pos (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        frame_start,
  input  logic                        cfg_write,
  input  logic [gaws_pkg::WidthW-1:0] width_eff,
  input  logic [gaws_pkg::SideW-1:0]  side,
  output gaws_pkg::pos_t              pos,
  output logic                        busy
);
  import gaws_pkg::*;

  logic [PixXW-1:0] px, px_c;
  logic [PixYW-1:0] py, py_c;
  logic [LocW-1:0]  lx, lx_c, ly, ly_c;
  logic [TileW-1:0] tx, tx_c, ty, ty_c;
  logic             recalc;

  logic [WidthW-1:0] span;
  logic [SideW-1:0]  side_m1;
  logic [WidthW-1:0] px_inc;
  logic [SideW-1:0]  lx_inc, ly_inc;
  logic              wrap;

  logic             busy_x, busy_y;
  logic [TileW-1:0] q_x, q_y;
  logic [LocW-1:0]  r_x, r_y;

  // position of the pixel on the input, frame start counts from the origin
  assign px_c = frame_start ? '0 : px;
  assign py_c = frame_start ? '0 : py;
  assign lx_c = frame_start ? '0 : lx;
  assign ly_c = frame_start ? '0 : ly;
  assign tx_c = frame_start ? '0 : tx;
  assign ty_c = frame_start ? '0 : ty;

  assign span    = {side, 4'b0000};
  assign side_m1 = SideW'(side - 1'b1);
  assign px_inc  = WidthW'({1'b0, px_c} + 1'b1);
  assign lx_inc  = SideW'({1'b0, lx_c} + 1'b1);
  assign ly_inc  = SideW'({1'b0, ly_c} + 1'b1);
  assign wrap    = px_inc >= width_eff;

  always_comb begin
    pos.start   = frame_start;
    pos.in_span = ({1'b0, px_c} < span) && (py_c < span);
    pos.first   = (lx_c == '0) && (ly_c == '0);
    pos.inner   = (lx_c != '0) && (ly_c != '0);
    pos.last    = ({1'b0, lx_c} == side_m1) && ({1'b0, ly_c} == side_m1);
    pos.lx      = lx_c;
    pos.tx      = tx_c;
    pos.ty      = ty_c;
  end

  gaws_div u_div_x (
    .clk         (clk),
    .rst         (rst),
    .start       (cfg_write),
    .dividend    ({1'b0, px}),
    .divisor     (side),
    .busy        (busy_x),
    .quotient_lo (q_x),
    .remainder   (r_x)
  );

  gaws_div u_div_y (
    .clk         (clk),
    .rst         (rst),
    .start       (cfg_write),
    .dividend    (py),
    .divisor     (side),
    .busy        (busy_y),
    .quotient_lo (q_y),
    .remainder   (r_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      px     <= '0;
      py     <= '0;
      lx     <= '0;
      ly     <= '0;
      tx     <= '0;
      ty     <= '0;
      recalc <= 1'b0;
    end else if (cfg_write) begin
      recalc <= 1'b1;
    end else if (recalc) begin
      if (!busy_x && !busy_y) begin
        lx     <= r_x;
        tx     <= q_x;
        ly     <= r_y;
        ty     <= q_y;
        recalc <= 1'b0;
      end
    end else if (accept) begin
      if (wrap) begin
        px <= '0;
        lx <= '0;
        tx <= '0;
        if (py_c < PixelYMax) begin
          py <= PixYW'(py_c + 1'b1);
          if (ly_inc == side) begin
            ly <= '0;
            ty <= TileW'(ty_c + 1'b1);
          end else begin
            ly <= ly_inc[LocW-1:0];
            ty <= ty_c;
          end
        end else begin
          py <= py_c;
          ly <= ly_c;
          ty <= ty_c;
        end
      end else begin
        px <= px_inc[PixXW-1:0];
        py <= py_c;
        ly <= ly_c;
        ty <= ty_c;
        if (lx_inc == side) begin
          lx <= '0;
          tx <= TileW'(tx_c + 1'b1);
        end else begin
          lx <= lx_inc[LocW-1:0];
          tx <= tx_c;
        end
      end
    end
  end

  assign busy = recalc;

endmodule

[hw/rtl/gaws_colmem.sv]
module gaws_colmem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        accept,
  input  logic [gaws_pkg::AlphaW-1:0] alpha,
  input  gaws_pkg::pos_t              pos,
  output gaws_pkg::done_t             done
);
  import gaws_pkg::*;

  logic [LocW-1:0] mem [GridTiles];
  logic [LocW-1:0] rdata;
  logic            rvalid;
  logic [GridTiles-1:0] vld;

  logic             s1_valid;
  logic             s1_start;
  logic             s1_first;
  logic             s1_examine;
  logic             s1_last;
  logic [LocW-1:0]  s1_lx;
  logic [TileW-1:0] s1_tx;
  logic [TileW-1:0] s1_ty;

  logic             fwd_valid;
  logic [TileW-1:0] fwd_addr;
  logic [LocW-1:0]  fwd_data;

  logic [LocW-1:0] cur, base, col_new;
  logic            clear;

  assign clear = accept && pos.start;

  always_comb begin
    if (s1_start) begin
      cur = '0;
    end else if (fwd_valid && (fwd_addr == s1_tx)) begin
      cur = fwd_data;
    end else if (rvalid) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    base    = s1_first ? '0 : cur;
    col_new = (s1_examine && (s1_lx > base)) ? s1_lx : base;
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      mem[s1_tx] <= col_new;
    end
    if (accept) begin
      rdata <= mem[pos.tx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      vld        <= '0;
      fwd_valid  <= 1'b0;
      done.valid <= 1'b0;
    end else if (advance) begin
      s1_valid   <= accept && pos.in_span;
      rvalid     <= vld[pos.tx];
      s1_start   <= pos.start;
      s1_first   <= pos.first;
      s1_examine <= pos.inner && (alpha != '0);
      s1_last    <= pos.last;
      s1_lx      <= pos.lx;
      s1_tx      <= pos.tx;
      s1_ty      <= pos.ty;

      if (clear) begin
        vld <= '0;
      end else if (s1_valid) begin
        vld[s1_tx] <= 1'b1;
      end

      fwd_valid <= s1_valid && !clear;
      fwd_addr  <= s1_tx;
      fwd_data  <= col_new;

      done.valid <= s1_valid && s1_last;
      done.glyph <= {s1_ty, s1_tx};
      done.col   <= col_new;
    end
  end

endmodule

[hw/rtl/gaws_frac.sv]
module gaws_frac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  gaws_pkg::done_t            done,
  input  logic [gaws_pkg::SideW-1:0] side,
  output logic                       result_valid,
  output gaws_pkg::result_t          result
);
  import gaws_pkg::*;

  logic [RecipW-1:0] recip_rom [MaxTileSide];
  logic [RecipW-1:0] recip;
  logic [NumW-1:0]   num;

  logic              p_valid;
  logic [GlyphW-1:0] p_glyph;
  logic [LocW-1:0]   p_col;
  logic [ProdW-1:0]  p_prod;
  logic [QuotW-1:0]  quot;
  logic [FracW-1:0]  frac;

  // ceiling reciprocal of each tile side, exact for every rounded quotient
  for (genvar g = 0; g < MaxTileSide; g++) begin : g_recip
    localparam longint unsigned Recip = ((64'd1 << RecipShift) + g) / (g + 1);
    assign recip_rom[g] = Recip[RecipW-1:0];
  end

  assign recip = recip_rom[LocW'(side - 1'b1)];
  assign num   = {done.col, FracW'(side >> 1)};

  assign quot = p_prod[ProdW-1:RecipShift];

  always_comb begin
    if (p_glyph == SpaceGlyph) begin
      frac = HalfQ16;
    end else if (quot > QuotW'(FracMax)) begin
      frac = FracMax;
    end else begin
      frac = quot[FracW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= done.valid;
      p_glyph <= done.glyph;
      p_col   <= done.col;
      p_prod  <= ProdW'(num) * ProdW'(recip);

      result_valid            <= p_valid;
      result.glyph_index      <= p_glyph;
      result.rightmost_column <= p_col;
      result.width_fraction   <= frac;
    end
  end

endmodule
